// ----- rtl/core/dfs_pkg.sv -----
// ----------------------------------------------------------------------------
// dfs_pkg
// Shared types and constants for the directional focus search block.
// ----------------------------------------------------------------------------
package dfs_pkg;

    localparam int ID_W          = 32;
    localparam int COORD_W       = 11;
    localparam int DIFF_W        = COORD_W + 1;
    localparam int SQ_W          = 2 * DIFF_W - 1;
    localparam int RAD_W         = 2 * DIFF_W;
    localparam int ROOT_W        = RAD_W / 2;
    localparam int DEFAULT_DEPTH = 48;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_t;

    localparam logic [2:0] DIR_NONE  = 3'd0;
    localparam logic [2:0] DIR_RIGHT = 3'd1;
    localparam logic [2:0] DIR_LEFT  = 3'd2;
    localparam logic [2:0] DIR_DOWN  = 3'd3;
    localparam logic [2:0] DIR_UP    = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0]           id;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND_RD,
        ST_FIND_CHK,
        ST_STEP,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_MUL,
        ST_SUM,
        ST_ROOT,
        ST_OUT
    } state_t;

endpackage

// ----- rtl/core/directional_focus_search.sv -----
// ----------------------------------------------------------------------------
// directional_focus_search
// Table of control rectangles; picks the next focus target by direction.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | role
//  ---------+-----------------------------------------+------------------------
//  s_       | s_valid s_ready s_command s_control_id  | clear / add / query
//           | s_x_left s_y_top s_x_right s_y_bottom   |
//           | s_direction                             |
//  m_       | m_valid m_ready m_next_id               | one answer per query
//
//  Clear and add are taken in the idle state. A query reads the entries in turn
//  to find the start entry, then walks the ring one entry at a time, and runs
//  each direction hit through the squares and the bit-serial square root.
//  Reset empties the table at once; entries are not cleared.
//  A finished answer waits in the output register; only a query that ends
//  while the previous answer is still untaken holds the block.
// ----------------------------------------------------------------------------
module directional_focus_search
    import dfs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_command,
    input  logic [ID_W-1:0]           s_control_id,
    input  logic signed [COORD_W-1:0] s_x_left,
    input  logic signed [COORD_W-1:0] s_y_top,
    input  logic signed [COORD_W-1:0] s_x_right,
    input  logic signed [COORD_W-1:0] s_y_bottom,
    input  logic [2:0]                s_direction,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [ID_W-1:0]           m_next_id
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  count_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  start_reg;
    logic [IDX_W-1:0]  cur_reg;
    logic [IDX_W-1:0]  cur_step;
    entry_t            start_ent_reg;
    logic [ID_W-1:0]   qid_reg;
    logic [2:0]        dir_reg;
    logic              have_reg;
    logic [ID_W-1:0]   best_id_reg;
    logic [ROOT_W-1:0] best_d_reg;
    logic [ID_W-1:0]   cand_id_reg;
    logic [ID_W-1:0]   result_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg;
    logic [SQ_W-1:0]   sx_reg, sy_reg;
    logic              m_valid_reg;
    logic [ID_W-1:0]   m_next_id_reg;

    logic              accept;
    cmd_t              cmd;
    logic              backward;
    logic              hit;
    logic              span;
    logic              out_free;
    logic              last_find;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    entry_t            rd_data;

    logic              sq_start;
    logic              sq_busy;
    logic              sq_done;
    logic [ROOT_W-1:0] sq_root;
    logic [RAD_W-1:0]  radicand;

    dfs_table #(.DEPTH(TABLE_DEPTH)) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dfs_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (radicand),
        .busy     (sq_busy),
        .done     (sq_done),
        .root     (sq_root)
    );

    assign accept    = s_valid && s_ready;
    assign cmd       = cmd_t'(s_command);
    assign backward  = (dir_reg == DIR_LEFT) || (dir_reg == DIR_UP);
    assign out_free  = !m_valid_reg || m_ready;
    assign last_find = ({1'b0, idx_reg} + 1'b1) >= {1'b0, count_reg};
    assign radicand  = RAD_W'(sx_reg) + RAD_W'(sy_reg);

    // ring step from the current entry
    always_comb begin
        if (backward) begin
            cur_step = (cur_reg == '0) ? IDX_W'(count_reg - 1'b1) : cur_reg - 1'b1;
        end else begin
            cur_step = (({1'b0, cur_reg} + 1'b1) >= {1'b0, count_reg}) ? '0
                                                                       : cur_reg + 1'b1;
        end
    end

    always_comb begin
        span = ((start_ent_reg.y1 >= rd_data.y1) && (start_ent_reg.y1 <= rd_data.y2)) ||
               ((start_ent_reg.y2 >= rd_data.y1) && (start_ent_reg.y2 <= rd_data.y2));
        case (dir_reg)
            DIR_RIGHT: hit = (start_ent_reg.x2 < rd_data.x1) && span;
            DIR_LEFT:  hit = (start_ent_reg.x1 > rd_data.x2) && span;
            DIR_DOWN:  hit = (start_ent_reg.y1 < rd_data.y1);
            DIR_UP:    hit = (rd_data.y1 < start_ent_reg.y1);
            default:   hit = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && cmd == CMD_QUERY) begin
                    if (s_direction == DIR_NONE || count_reg == '0) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_FIND_RD;
                    end
                end
            end
            ST_FIND_RD:  state_next = ST_FIND_CHK;
            ST_FIND_CHK: begin
                if (rd_data.id == qid_reg || last_find) begin
                    state_next = ST_STEP;
                end else begin
                    state_next = ST_FIND_RD;
                end
            end
            ST_STEP:     state_next = (cur_step == start_reg) ? ST_OUT : ST_WALK_RD;
            ST_WALK_RD:  state_next = ST_WALK_CHK;
            ST_WALK_CHK: begin
                if (dir_reg > DIR_UP) begin
                    state_next = ST_OUT;
                end else if (hit) begin
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_STEP;
                end
            end
            ST_MUL:      state_next = ST_SUM;
            ST_SUM:      state_next = ST_ROOT;
            ST_ROOT:     state_next = sq_done ? ST_STEP : ST_ROOT;
            ST_OUT:      state_next = out_free ? ST_IDLE : ST_OUT;
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs and memory ports
    always_comb begin
        s_ready  = (state_reg == ST_IDLE);
        rd_en    = (state_reg == ST_FIND_RD) || (state_reg == ST_WALK_RD);
        rd_addr  = (state_reg == ST_FIND_RD) ? idx_reg : cur_reg;
        sq_start = (state_reg == ST_SUM) && !sq_busy;
        wr_en    = accept && cmd == CMD_ADD && s_control_id != '0;
        wr_addr  = (count_reg >= CNT_W'(TABLE_DEPTH)) ? '0 : IDX_W'(count_reg);
        wr_data  = '{id: s_control_id, x1: s_x_left, y1: s_y_top,
                     x2: s_x_right, y2: s_y_bottom};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            have_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        case (cmd)
                            CMD_CLEAR: count_reg <= '0;
                            CMD_ADD: begin
                                if (s_control_id != '0) begin
                                    count_reg <= (count_reg >= CNT_W'(TABLE_DEPTH))
                                                 ? CNT_W'(1) : count_reg + 1'b1;
                                end
                            end
                            default: ;
                        endcase
                        qid_reg    <= s_control_id;
                        dir_reg    <= s_direction;
                        result_reg <= s_control_id;
                        idx_reg    <= '0;
                        have_reg   <= 1'b0;
                    end
                end
                ST_FIND_CHK: begin
                    // keep entry 0 as the start unless the id turns up
                    if (idx_reg == '0 || rd_data.id == qid_reg) begin
                        start_ent_reg <= rd_data;
                        start_reg     <= idx_reg;
                        cur_reg       <= idx_reg;
                    end
                    idx_reg <= idx_reg + 1'b1;
                end
                ST_STEP: begin
                    if (cur_step == start_reg) begin
                        result_reg <= have_reg ? best_id_reg : start_ent_reg.id;
                    end
                    cur_reg <= cur_step;
                end
                ST_WALK_CHK: begin
                    result_reg  <= rd_data.id;
                    cand_id_reg <= rd_data.id;
                    dx_reg <= DIFF_W'(start_ent_reg.x1) - DIFF_W'(rd_data.x1);
                    dy_reg <= DIFF_W'(start_ent_reg.y1) - DIFF_W'(rd_data.y1);
                end
                ST_MUL: begin
                    sx_reg <= SQ_W'(dx_reg * dx_reg);
                    sy_reg <= SQ_W'(dy_reg * dy_reg);
                end
                ST_ROOT: begin
                    if (sq_done && (!have_reg || sq_root < best_d_reg)) begin
                        have_reg    <= 1'b1;
                        best_id_reg <= cand_id_reg;
                        best_d_reg  <= sq_root;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_valid_reg   <= 1'b1;
                        m_next_id_reg <= result_reg;
                    end else begin
                        m_valid_reg   <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_next_id = m_next_id_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_root_state: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_done |-> state_reg == ST_ROOT)
        else $error("square root finished outside its wait state");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && out_free) |=> m_valid_reg && state_reg == ST_IDLE)
        else $error("answer not loaded into output register");
`endif

endmodule

// ----- rtl/core/dfs_table.sv -----
// ----------------------------------------------------------------------------
// dfs_table
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dfs_table
    import dfs_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  entry_t                   wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output entry_t                   rd_data
);

    entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/core/dfs_sqrt.sv -----
// ----------------------------------------------------------------------------
// dfs_sqrt
// Iterative floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module dfs_sqrt
    import dfs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic              busy,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int REM_W = ROOT_W + 3;
    localparam int CNT_W = $clog2(ROOT_W);

    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1:RAD_W-2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= CNT_W'(ROOT_W - 1);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg  <= ge ? rem_sh - trial : rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], ge};
                rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = root_reg;

endmodule
